// ===== sv/ihp_pkg.sv =====
package ihp_pkg;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_RECORD  = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_COLON  = 3'd1,
    ERR_BAD_DIGIT = 3'd2,
    ERR_SHORT     = 3'd3,
    ERR_LENGTH    = 3'd4,
    ERR_CHECKSUM  = 3'd5,
    ERR_ADDR_REC  = 3'd6,
    ERR_NO_END    = 3'd7
  } err_t;

  localparam logic [7:0] REC_DATA  = 8'h00;
  localparam logic [7:0] REC_EOF   = 8'h01;
  localparam logic [7:0] REC_SEG   = 8'h02;
  localparam logic [7:0] REC_START = 8'h03;
  localparam logic [7:0] REC_LIN   = 8'h04;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [8:0] IDX_LENGTH  = 9'd0;
  localparam logic [8:0] IDX_ADDR_HI = 9'd1;
  localparam logic [8:0] IDX_ADDR_LO = 9'd2;
  localparam logic [8:0] IDX_TYPE    = 9'd3;
  localparam logic [8:0] IDX_DATA0   = 9'd4;
  localparam logic [8:0] IDX_DATA1   = 9'd5;
  localparam logic [8:0] HEAD_BYTES  = 9'd4;
  localparam logic [8:0] FRAME_BYTES = 9'd5;
  localparam logic [8:0] COUNT_MAX   = 9'd511;

  localparam logic CFG_ADDR_OFFSET = 1'b0;
  localparam logic CFG_SEG_OFFSET  = 1'b1;

  localparam int TDATA_W = 88;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic [31:0] segment_value;
    logic [7:0]  record_type;
    err_t        error_code;
  } result_t;

  typedef struct packed {
    logic        we;
    logic        index;
    logic [31:0] data;
  } cfg_wr_t;

  // bit 4 flags a valid digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    case (c) inside
      [8'h30:8'h39]:               r = {1'b1, c[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:                     r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ihp_in_reg.sv =====
module ihp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              out_free,
  output logic              in_valid,
  output ihp_pkg::in_item_t in_item
);
  import ihp_pkg::*;

  logic load;

  assign s_axis_tready = !in_valid || out_free;
  assign load = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (load) begin
      in_valid <= 1'b1;
    end else if (out_free) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_item.char_in      <= s_axis_tdata;
      in_item.end_of_input <= s_axis_tuser;
    end
  end

endmodule

// ===== sv/ihp_core.sv =====
module ihp_core (
  input  logic              clk,
  input  logic              rst,
  input  ihp_pkg::cfg_wr_t  cfg,
  input  logic              go,
  input  ihp_pkg::in_item_t in_item,
  output logic              res_valid,
  output ihp_pkg::result_t  res
);
  import ihp_pkg::*;

  logic [31:0] address_offset;
  logic [31:0] segment_offset;

  phase_t      phase, phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        digit_odd, digit_odd_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [7:0]  declared_length, declared_length_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] first_two_data, first_two_data_next;
  logic [19:0] segment_base, segment_base_next;
  logic [31:0] upper_base, upper_base_next;
  logic [15:0] segment_register, segment_register_next;
  logic [31:0] cur_addr, cur_addr_next;

  logic [4:0]  hx;
  logic [7:0]  b;
  logic        is_eol;
  logic        close_eof;
  err_t        close_err;

  assign hx     = hex_digit(in_item.char_in);
  assign b      = {high_nibble, hx[3:0]};
  assign is_eol = (in_item.char_in == CH_CR) || (in_item.char_in == CH_LF);

  always_ff @(posedge clk) begin
    if (rst) begin
      address_offset <= '0;
      segment_offset <= '0;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_ADDR_OFFSET: address_offset <= cfg.data;
        CFG_SEG_OFFSET:  segment_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr <= '0;
    end else begin
      cur_addr <= cur_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_BETWEEN;
      high_nibble      <= '0;
      digit_odd        <= 1'b0;
      byte_count       <= '0;
      declared_length  <= '0;
      record_address   <= '0;
      type_byte        <= '0;
      running_sum      <= '0;
      first_two_data   <= '0;
      segment_base     <= '0;
      upper_base       <= '0;
      segment_register <= '0;
    end else begin
      phase            <= phase_next;
      high_nibble      <= high_nibble_next;
      digit_odd        <= digit_odd_next;
      byte_count       <= byte_count_next;
      declared_length  <= declared_length_next;
      record_address   <= record_address_next;
      type_byte        <= type_byte_next;
      running_sum      <= running_sum_next;
      first_two_data   <= first_two_data_next;
      segment_base     <= segment_base_next;
      upper_base       <= upper_base_next;
      segment_register <= segment_register_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    high_nibble_next      = high_nibble;
    digit_odd_next        = digit_odd;
    byte_count_next       = byte_count;
    declared_length_next  = declared_length;
    record_address_next   = record_address;
    type_byte_next        = type_byte;
    running_sum_next      = running_sum;
    first_two_data_next   = first_two_data;
    segment_base_next     = segment_base;
    upper_base_next       = upper_base;
    segment_register_next = segment_register;
    cur_addr_next         = cur_addr;
    res_valid             = 1'b0;
    res                   = '0;
    close_err             = ERR_NONE;
    close_eof             = 1'b0;

    if (go) begin
      case (phase)
        PH_BETWEEN: begin
          if (in_item.end_of_input) begin
            res_valid  = 1'b1;
            res.kind   = KIND_END;
            phase_next = PH_STOPPED;
          end else if (is_eol) begin
          end else if (in_item.char_in == CH_COLON) begin
            high_nibble_next     = '0;
            digit_odd_next       = 1'b0;
            byte_count_next      = '0;
            declared_length_next = '0;
            record_address_next  = '0;
            type_byte_next       = '0;
            running_sum_next     = '0;
            first_two_data_next  = '0;
            phase_next           = PH_RECORD;
          end else begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NO_COLON;
            phase_next     = PH_STOPPED;
          end
        end

        PH_RECORD: begin
          if (in_item.end_of_input || is_eol) begin
            phase_next = PH_BETWEEN;
            if (digit_odd || byte_count < FRAME_BYTES) begin
              close_err = ERR_SHORT;
            end else if (byte_count != {1'b0, declared_length} + FRAME_BYTES) begin
              close_err = ERR_LENGTH;
            end else if (running_sum != 8'h00) begin
              close_err = ERR_CHECKSUM;
            end else begin
              case (type_byte)
                REC_EOF: close_eof = 1'b1;
                REC_SEG: begin
                  if (declared_length != 8'd2 || record_address != 16'h0000) begin
                    close_err = ERR_ADDR_REC;
                  end else begin
                    segment_base_next = {first_two_data, 4'h0};
                  end
                end
                REC_START: begin
                  if (declared_length < 8'd2 || record_address != 16'h0000) begin
                    close_err = ERR_ADDR_REC;
                  end else begin
                    segment_register_next = first_two_data;
                  end
                end
                REC_LIN: begin
                  if (declared_length != 8'd2 || record_address != 16'h0000) begin
                    close_err = ERR_ADDR_REC;
                  end else begin
                    upper_base_next = {first_two_data, 16'h0000};
                  end
                end
                default: ;
              endcase
              if (close_err == ERR_NONE && !close_eof && in_item.end_of_input) begin
                close_err = ERR_NO_END;
              end
            end
            res_valid       = 1'b1;
            res.record_type = type_byte;
            if (close_err != ERR_NONE) begin
              res.kind       = KIND_ERROR;
              res.error_code = close_err;
              phase_next     = PH_STOPPED;
            end else if (close_eof) begin
              res.kind   = KIND_END;
              phase_next = PH_STOPPED;
            end else begin
              res.kind = KIND_ACCEPT;
            end
          end else if (!hx[4]) begin
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_code  = ERR_BAD_DIGIT;
            res.record_type = type_byte;
            phase_next      = PH_STOPPED;
          end else if (!digit_odd) begin
            high_nibble_next = hx[3:0];
            digit_odd_next   = 1'b1;
          end else begin
            digit_odd_next   = 1'b0;
            running_sum_next = running_sum + b;
            if (byte_count != COUNT_MAX) begin
              byte_count_next = byte_count + 9'd1;
            end
            case (byte_count)
              IDX_LENGTH:  declared_length_next = b;
              IDX_ADDR_HI: record_address_next[15:8] = b;
              IDX_ADDR_LO: begin
                record_address_next[7:0] = b;
                cur_addr_next = {12'h000, segment_base} + upper_base
                                + {16'h0000, record_address[15:8], b};
              end
              IDX_TYPE:    type_byte_next = b;
              IDX_DATA0:   first_two_data_next[15:8] = b;
              IDX_DATA1:   first_two_data_next[7:0] = b;
              default: ;
            endcase
            if (byte_count >= HEAD_BYTES) begin
              cur_addr_next = cur_addr + 32'd1;
            end
            if (type_byte == REC_DATA && byte_count >= HEAD_BYTES
                && byte_count < {1'b0, declared_length} + HEAD_BYTES) begin
              res_valid         = 1'b1;
              res.kind          = KIND_DATA;
              res.data_byte     = b;
              res.byte_address  = cur_addr + address_offset;
              res.segment_value = {16'h0000, segment_register} + segment_offset;
            end
          end
        end

        default: ;
      endcase
    end
  end

endmodule

// ===== sv/ihp_out_reg.sv =====
module ihp_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  ihp_pkg::result_t               res,
  output logic                           out_free,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ihp_pkg::TDATA_W-1:0]    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser
);
  import ihp_pkg::*;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tuser <= res.kind;
      m_axis_tdata <= {5'b00000, res.error_code, res.record_type, res.segment_value,
                       res.byte_address, res.data_byte};
    end
  end

endmodule

// ===== sv/intel_hex_record_parser_top.sv =====
// Intel HEX record parser.
// Input stream: one text character per item in s_axis_tdata, with s_axis_tuser
// high marking end of file. Output stream: at most one result per input item,
// its kind in m_axis_tuser (data byte, record accepted, file ended, error) and
// the byte, its 32-bit address, segment value, record type and error code
// in m_axis_tdata.
// Configuration: cfg_we writes cfg_data into the address offset (index 0) or
// the segment offset (index 1) at the clock edge; write only while idle.
// Throughput: one character per cycle unless the receiver stalls. An item passes
// an input register, then the per-character decode updates the record state and
// loads the output register, from which the result is presented.
// Data bytes leave as soon as their digit pair completes; the record's
// checks are reported when CR, LF or end of file closes it. An error or an
// end-of-file record halts the parser: further items are taken and dropped.
// Reset clears the parser state, both offsets and both registers' valid flags.
// When the receiver stalls the output register holds its result, the input
// register holds the next item, and s_axis_tready drops until the result goes.
module intel_hex_record_parser_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // char_in
  input  logic                         s_axis_tuser,  // end_of_input
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // data_byte, byte_address, segment_value, record_type, error_code, zero fill
  output logic [ihp_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,  // result_kind
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [31:0]                  cfg_data
);
  import ihp_pkg::*;

  logic     out_free;
  logic     in_valid;
  in_item_t in_item;
  logic     go;
  logic     res_valid;
  result_t  res;
  cfg_wr_t  cfg;

  assign go        = in_valid && out_free;
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ihp_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .out_free      (out_free),
    .in_valid      (in_valid),
    .in_item       (in_item)
  );

  ihp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .go        (go),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ihp_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (go && res_valid),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    go && res_valid |=> m_axis_tvalid)
    else $error("result not presented after decode");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid)
    else $error("pending item dropped while output stalled");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_ERROR |-> m_axis_tdata[82:80] == 3'd0)
    else $error("error code on a non-error result");

  a_data_not_at_eof: assert property (@(posedge clk) disable iff (rst)
    go && res_valid && res.kind == KIND_DATA |-> !in_item.end_of_input)
    else $error("data byte produced by end of file");

endmodule
